@@ sv/alul_pkg.sv @@
// ---------------------------------------------------------------------------
// alul_pkg: shared types and constants of the array list table
// Sizes of the list store, request and result codes, and the
// structures that pass between the sequencer, the store and the top level.
// ---------------------------------------------------------------------------
package alul_pkg;

    // Size of the list store.
    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed widths of the item fields.
    localparam int MODE_W   = 3;
    localparam int POS_W    = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 10;
    localparam int FILL_W   = 11;

    // Width used to compare a position against the fill count.
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Request codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_INSERT_AT = 3'd1,
        MODE_DELETE_AT = 3'd2,
        MODE_DELETE_VAL = 3'd3,
        MODE_DELETE_LAST = 3'd4,
        MODE_CLEAR     = 3'd5,
        MODE_SEARCH    = 3'd6
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MOVE,
        ST_INSERT,
        ST_SCAN,
        ST_REMOVE,
        ST_RESP
    } t_state;

    // One access to the list store: write port and read address.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_cmd;

    // One finished result on its way to the output register.
    typedef struct packed {
        t_status           status;
        logic [FOUND_W-1:0] found_index;
        logic [FILL_W-1:0]  fill_count;
    } t_result;

endpackage

@@ sv/alul_if.sv @@
// ---------------------------------------------------------------------------
// alul_req_if / alul_rsp_if: item channels of the array list table
// Valid/ready channels for requests and for results.
// ---------------------------------------------------------------------------

// Request channel: one item per list operation.
interface alul_req_if
    import alul_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output position, output value,
                    input ready);
    modport sink   (input valid, input mode, input position, input value,
                    output ready);
endinterface

// Result channel: one item per request.
interface alul_rsp_if
    import alul_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output status, output found_index,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input found_index,
                    input fill_count, output ready);
endinterface

@@ sv/unordered_array_list_table.sv @@
// ---------------------------------------------------------------------------
// unordered_array_list_table: fixed-capacity unordered list of signed words
// Append, insert, delete, clear and search on a list kept in one RAM,
// with a fill count and one result item for each request item.
// ---------------------------------------------------------------------------
//  channel  | direction | fields
//  ---------+-----------+-----------------------------------------
//  i_req    | in        | mode[2:0] position[9:0] value[31:0]
//  o_rsp    | out       | status[1:0] found_index[9:0] fill_count[10:0]
//
//  Append, delete-last, clear and unused codes finish at the decode step;
//  delete-at and insert-at go on to further steps (read, move, write back).
//  Search and delete-value scan up to fill_count entries:
//  the single RAM read port scans one entry a cycle.
//  Reset clears the fill count and the sequencer; the RAM is not cleared.
//  The output register holds a result while o_rsp is stalled; the next
//  item is taken meanwhile, and a second finished result waits in place.
// ---------------------------------------------------------------------------
module unordered_array_list_table
    import alul_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    alul_req_if.sink   i_req,
    alul_rsp_if.source o_rsp
);

    t_mem_cmd              w_mem;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  w_res_valid;
    logic                  w_res_ready;
    t_result               w_res;

    logic                  r_out_valid;
    t_result               r_out;

    // Sequencer.
    alul_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rdata     (w_rdata),
        .o_mem       (w_mem),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // List store.
    alul_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Output register: takes a result when empty or being emptied.
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found_index = r_out.found_index;
    assign o_rsp.fill_count  = r_out.fill_count;

endmodule

@@ sv/alul_ram.sv @@
// ---------------------------------------------------------------------------
// alul_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module alul_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/alul_ctrl.sv @@
// ---------------------------------------------------------------------------
// alul_ctrl: list sequencer
// Holds the fill count, decodes each request and drives the list store
// through read, modify and write-back steps, one entry per cycle in a scan.
// ---------------------------------------------------------------------------
module alul_ctrl
    import alul_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    alul_req_if.sink              i_req,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    output t_mem_cmd              o_mem,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    t_mode                 r_mode, n_mode;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_found, n_found;
    logic [ADDR_W-1:0]     r_target, n_target;
    logic [ADDR_W-1:0]     r_scan_idx, n_scan_idx;

    logic                  w_accept;
    logic [CNT_W-1:0]      w_last;
    logic                  w_pos_ok;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_hit;
    logic                  w_scan_end;

    // Decisions shared by the next-state and output logic.
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_last     = r_count - CNT_W'(1);
    assign w_pos_ok   = CMP_W'(r_pos) < CMP_W'(r_count);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_hit      = (i_rdata == r_value);
    assign w_scan_end = (CNT_W'(r_scan_idx) == w_last);

    assign i_req.ready = (r_state == ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (r_mode)
                    MODE_INSERT_AT: begin
                        n_state = (w_pos_ok && !w_full) ? ST_MOVE : ST_RESP;
                    end
                    MODE_DELETE_AT: begin
                        n_state = w_pos_ok ? ST_REMOVE : ST_RESP;
                    end
                    MODE_DELETE_VAL, MODE_SEARCH: begin
                        n_state = w_empty ? ST_RESP : ST_SCAN;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_MOVE:   n_state = ST_INSERT;
            ST_INSERT: n_state = ST_RESP;
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = (r_mode == MODE_DELETE_VAL) ? ST_REMOVE : ST_RESP;
                end else if (w_scan_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_REMOVE: n_state = ST_RESP;
            ST_RESP: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, store accesses and result fields.
    always_comb begin
        n_count    = r_count;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_value    = r_value;
        n_status   = r_status;
        n_found    = r_found;
        n_target   = r_target;
        n_scan_idx = r_scan_idx;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_target;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_scan_idx + ADDR_W'(1);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode   = t_mode'(i_req.mode);
                    n_pos    = i_req.position;
                    n_value  = i_req.value[DATA_WIDTH-1:0];
                    n_status = STATUS_OK;
                    n_found  = '0;
                end
            end
            ST_DECIDE: begin
                case (r_mode)
                    MODE_APPEND: begin
                        if (w_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = ADDR_W'(r_count);
                            o_mem.wdata = r_value;
                            n_count     = r_count + CNT_W'(1);
                        end
                    end
                    MODE_INSERT_AT: begin
                        // Range test comes before the full test.
                        if (!w_pos_ok) begin
                            n_status = STATUS_MISS;
                        end else if (w_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            o_mem.raddr = ADDR_W'(r_pos);
                            n_target    = ADDR_W'(r_pos);
                        end
                    end
                    MODE_DELETE_AT: begin
                        if (!w_pos_ok) begin
                            n_status = STATUS_MISS;
                        end else begin
                            o_mem.raddr = ADDR_W'(w_last);
                            n_target    = ADDR_W'(r_pos);
                        end
                    end
                    MODE_DELETE_VAL, MODE_SEARCH: begin
                        if (w_empty) begin
                            n_status = STATUS_MISS;
                        end else begin
                            o_mem.raddr = '0;
                            n_scan_idx  = '0;
                        end
                    end
                    MODE_DELETE_LAST: begin
                        if (w_empty) begin
                            n_status = STATUS_MISS;
                        end else begin
                            n_count = w_last;
                        end
                    end
                    MODE_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = STATUS_MISS;
                    end
                endcase
            end
            ST_MOVE: begin
                // The old entry at the position goes to the end.
                o_mem.we    = 1'b1;
                o_mem.waddr = ADDR_W'(r_count);
                o_mem.wdata = i_rdata;
            end
            ST_INSERT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_target;
                o_mem.wdata = r_value;
                n_count     = r_count + CNT_W'(1);
            end
            ST_SCAN: begin
                // Read data belongs to r_scan_idx; the next address is already out.
                if (w_hit) begin
                    n_found     = r_scan_idx;
                    n_target    = r_scan_idx;
                    o_mem.raddr = ADDR_W'(w_last);
                end else if (w_scan_end) begin
                    n_status = STATUS_MISS;
                end else begin
                    n_scan_idx = r_scan_idx + ADDR_W'(1);
                end
            end
            ST_REMOVE: begin
                // The last entry fills the hole.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_target;
                o_mem.wdata = i_rdata;
                n_count     = w_last;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Request and result holding registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_pos      <= n_pos;
        r_value    <= n_value;
        r_status   <= n_status;
        r_found    <= n_found;
        r_target   <= n_target;
        r_scan_idx <= n_scan_idx;
    end

    assign o_res_valid      = (r_state == ST_RESP);
    assign o_res.status      = r_status;
    assign o_res.found_index = FOUND_W'(r_found);
    assign o_res.fill_count  = FILL_W'(r_count);

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A full report only comes from a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_status == STATUS_FULL) |-> w_full)
        else $error("full status with room left");

    // No store write while waiting for a request or handing over a result.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESP) |-> !o_mem.we)
        else $error("store written outside an operation");

    // A scan step leaves the fill count alone.
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> $stable(r_count))
        else $error("fill count changed during a scan");

    // An accepted request is decoded in the next cycle.
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DECIDE))
        else $error("accepted request not decoded");

endmodule
